### hw/rtl/pfce_pkg.sv
// Shared types and constants for the packet field change extractor.
package pfce_pkg;

  localparam int NUM_SLOTS_DEF   = 16;
  localparam int MAX_PKT_DEF     = 256;
  localparam int VALUE_BITS_DEF  = 32;
  localparam int POS_W           = 13;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_BYTE   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;
  localparam logic [1:0] ACT_RSVD   = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  src_addr;
    logic [6:0]  dst_addr;
    logic [62:0] timestamp;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [3:0]  slot;
    logic [10:0] field_pos;
    logic [5:0]  field_size;
    logic        is_signed;
    logic        slot_enable;
  } item_t;

  typedef struct packed {
    logic [3:0]  signal_slot;
    logic [62:0] start_time;
    logic [62:0] end_time;
    logic [31:0] value_out;
    logic        out_of_range;
    logic        last_event;
  } result_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic        load;
    logic        take;
    logic        eval;
    logic        finish;
    logic        clear;
    logic        shift;
  } cell_ctl_t;

endpackage

### hw/rtl/packet_field_change_extractor.sv
// Top level: slot cell chain, packet byte counter and result output register.
// Loads and non-final bytes leave the block ready for the next word. A final
// byte is latched and then evaluated in every slot in parallel; a final byte
// or finish then drains the pending results down the cell chain towards slot 0,
// one cell per cycle unless a result at slot 0 waits on a stalled output, and
// no word is taken until the drain ends. Results leave in slot order; last_event
// marks the final one. The output register lets the next word be taken while a result waits.
module packet_field_change_extractor #(
  parameter int NUM_SLOTS        = pfce_pkg::NUM_SLOTS_DEF,
  parameter int MAX_PACKET_BYTES = pfce_pkg::MAX_PKT_DEF,
  parameter int VALUE_BITS       = pfce_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  pfce_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output pfce_pkg::result_t result
);

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [PW-1:0] MAXB = PW'(MAX_PACKET_BYTES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state;
  logic [PW-1:0]     byte_index, len, len_next;
  logic [6:0]        pkt_src, pkt_dst;
  logic [62:0]       pkt_time;
  logic              acc;
  logic              out_free;
  pfce_pkg::cell_ctl_t ctl;
  logic [NUM_SLOTS:0] pv;
  pfce_pkg::result_t  pr [NUM_SLOTS+1];
  pfce_pkg::result_t  head;

  assign item_stall = (state != ST_IDLE);
  assign acc        = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign len_next   = (byte_index < MAXB) ? byte_index + 1'b1 : MAXB;

  always_comb begin
    ctl.load   = acc && (item.action == pfce_pkg::ACT_LOAD);
    ctl.take   = acc && (item.action == pfce_pkg::ACT_BYTE) && (byte_index < MAXB);
    ctl.eval   = (state == ST_EVAL);
    ctl.finish = acc && (item.action == pfce_pkg::ACT_FINISH);
    ctl.clear  = ctl.finish || (state == ST_EVAL);
    ctl.shift  = (state == ST_DRAIN) && (!pv[0] || out_free);
  end

  // head of chain, flagged last when nothing is pending behind it
  always_comb begin
    head            = pr[0];
    head.last_event = ~|pv[NUM_SLOTS:1];
  end

  assign pv[NUM_SLOTS] = 1'b0;
  assign pr[NUM_SLOTS] = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    pfce_cell #(.IDX(i), .VALUE_BITS(VALUE_BITS), .PW(PW)) u_cell (
      .clk, .rst, .ctl, .item,
      .pos(byte_index), .len, .pkt_src, .pkt_dst, .pkt_time,
      .pend_v_in(pv[i+1]), .pend_in(pr[i+1]),
      .pend_v(pv[i]), .pend(pr[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      byte_index   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (ctl.shift && pv[0]) begin
        result_valid <= 1'b1;
        result       <= head;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            case (item.action)
              pfce_pkg::ACT_BYTE: begin
                if (item.last_byte) begin
                  state      <= ST_EVAL;
                  len        <= len_next;
                  pkt_src    <= item.src_addr;
                  pkt_dst    <= item.dst_addr;
                  pkt_time   <= item.timestamp;
                  byte_index <= '0;
                end else begin
                  byte_index <= len_next;
                end
              end
              pfce_pkg::ACT_FINISH: begin
                byte_index <= '0;
                state      <= ST_DRAIN;
              end
              default: ;
            endcase
          end
        end
        ST_EVAL: state <= ST_DRAIN;
        ST_DRAIN: begin
          if (~|pv) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/pfce_cell.sv
// One slot cell: descriptor, byte accumulator, held value and a pending result stage.
module pfce_cell #(
  parameter int IDX        = 0,
  parameter int VALUE_BITS = pfce_pkg::VALUE_BITS_DEF,
  parameter int PW         = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  pfce_pkg::cell_ctl_t ctl,
  input  pfce_pkg::item_t    item,
  input  logic [PW-1:0]      pos,
  input  logic [PW-1:0]      len,
  input  logic [6:0]         pkt_src,
  input  logic [6:0]         pkt_dst,
  input  logic [62:0]        pkt_time,
  input  logic               pend_v_in,
  input  pfce_pkg::result_t  pend_in,
  output logic               pend_v,
  output pfce_pkg::result_t  pend
);

  localparam logic [31:0] VMASK = 32'((64'd1 << VALUE_BITS) - 64'd1);
  localparam logic [6:0]  VB    = 7'(VALUE_BITS);

  logic [6:0]  src, dst;
  logic [10:0] offset;
  logic [5:0]  width;
  logic        sgn, enable;
  logic [31:0] accum;
  logic [31:0] held;
  logic [62:0] since;
  logic        active, overrun;

  logic [6:0]  w;
  logic [pfce_pkg::POS_W-1:0] endb, first, last, p_ext, l_ext, miss;
  logic [7:0]  bmask, bval;
  logic [31:0] v0, v1, v2, sx;
  logic        in_rng, match, over;

  always_comb begin
    if (width == 6'd0) w = 7'd1;
    else if ({1'b0, width} > VB) w = VB;
    else w = {1'b0, width};
    endb  = pfce_pkg::POS_W'(offset) + pfce_pkg::POS_W'(w);
    first = pfce_pkg::POS_W'(offset[10:3]);
    last  = (endb - 1'b1) >> 3;
    p_ext = pfce_pkg::POS_W'(pos);
    l_ext = pfce_pkg::POS_W'(len);
    in_rng = (p_ext >= first) && (p_ext <= last);
    bmask = 8'hff;
    if (p_ext == first) bmask = bmask & (8'hff << offset[2:0]);
    if (p_ext == last)  bmask = bmask & (8'hff >> (3'd7 - endb[2:0] + 3'd1));
    bval  = item.data_byte & bmask;

    match = enable && (src == pkt_src) && (dst == pkt_dst);
    over  = last >= l_ext;
    miss  = last - l_ext + 1'b1;
    v0 = accum;
    if (over) begin
      if (miss >= 4) v0 = '0;
      else v0 = (accum << {miss[1:0], 3'b000}) & VMASK;
    end
    v1 = v0 >> offset[2:0];
    sx = VMASK & ~32'((33'd1 << w) - 33'd1);
    v2 = v1;
    if (sgn && (w < VB) && v1[5'(w - 7'd1)]) v2 = v1 | sx;
    v2 = v2 & VMASK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b0;
      accum   <= '0;
      active  <= 1'b0;
      overrun <= 1'b0;
      pend_v  <= 1'b0;
    end else begin
      if (ctl.shift) begin
        pend_v <= pend_v_in;
        pend   <= pend_in;
      end
      if (ctl.take && in_rng) accum <= ((accum << 8) | 32'(bval)) & VMASK;
      if (ctl.clear) accum <= '0;
      if (ctl.eval && match) begin
        if (!active || v2 != held) begin
          held    <= v2;
          since   <= pkt_time;
          overrun <= over;
          active  <= 1'b1;
        end
        if (active && v2 != held) begin
          pend_v <= 1'b1;
          pend   <= '{signal_slot: 4'(IDX), start_time: since, end_time: pkt_time,
                      value_out: held, out_of_range: overrun, last_event: 1'b0};
        end
      end
      if (ctl.finish && active) begin
        active <= 1'b0;
        pend_v <= 1'b1;
        pend   <= '{signal_slot: 4'(IDX), start_time: since, end_time: item.timestamp,
                    value_out: held, out_of_range: overrun, last_event: 1'b0};
      end
      if (ctl.load && (item.slot == 4'(IDX))) begin
        src     <= item.src_addr;
        dst     <= item.dst_addr;
        offset  <= item.field_pos;
        width   <= item.field_size;
        sgn     <= item.is_signed;
        enable  <= item.slot_enable;
        accum   <= '0;
        active  <= 1'b0;
        overrun <= 1'b0;
      end
    end
  end

endmodule

### dv/tb_top.sv
// Testbench for the packet field change extractor: directed and random words, self-checking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int MAXB  = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  pfce_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  pfce_pkg::result_t result;

  packet_field_change_extractor DUT (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall),
    .item(item), .result_valid(result_valid), .result_stall(result_stall),
    .result(result)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [6:0]  sl_src [NSLOT];
  logic [6:0]  sl_dst [NSLOT];
  logic [10:0] sl_off [NSLOT];
  logic [5:0]  sl_wid [NSLOT];
  logic        sl_sgn [NSLOT];
  logic        sl_en  [NSLOT];
  logic [31:0] accum  [NSLOT];
  logic [31:0] held   [NSLOT];
  logic [62:0] since  [NSLOT];
  logic        active [NSLOT];
  logic        overrun[NSLOT];
  int unsigned pos;

  pfce_pkg::result_t expected_q[$];
  int errors = 0;
  bit idle_on = 1'b1;
  longint cycles = 0;

  function automatic int unsigned eff_w(logic [5:0] w);
    if (w == 0) return 1;
    if (w > 32) return 32;
    return w;
  endfunction

  task automatic emit_change(int s, logic [62:0] t);
    pfce_pkg::result_t r;
    r.signal_slot  = s[3:0];
    r.start_time   = since[s];
    r.end_time     = t;
    r.value_out    = held[s];
    r.out_of_range = overrun[s];
    r.last_event   = 1'b0;
    expected_q.push_back(r);
  endtask

  task automatic predict(pfce_pkg::item_t it);
    int n;
    int unsigned w, first, fin, lst, len, miss;
    logic [31:0] v;
    logic [7:0] b;
    bit ovr;
    n = 0;
    if (it.action == pfce_pkg::ACT_LOAD) begin
      sl_src[it.slot] = it.src_addr; sl_dst[it.slot] = it.dst_addr;
      sl_off[it.slot] = it.field_pos; sl_wid[it.slot] = it.field_size;
      sl_sgn[it.slot] = it.is_signed; sl_en[it.slot] = it.slot_enable;
      accum[it.slot] = '0; active[it.slot] = 0; overrun[it.slot] = 0;
    end else if (it.action == pfce_pkg::ACT_BYTE) begin
      if (pos < MAXB) begin
        for (int s = 0; s < NSLOT; s++) begin
          w = eff_w(sl_wid[s]);
          first = sl_off[s] / 8;
          fin = sl_off[s] + w;
          lst = (fin - 1) / 8;
          b = it.data_byte;
          if (pos < first || pos > lst) continue;
          if (pos == first) b &= 8'hff << (sl_off[s] % 8);
          if (pos == lst) b &= 8'hff >> (7 - ((fin - 1) % 8));
          accum[s] = {accum[s][23:0], b};
        end
        len = pos + 1;
      end else len = MAXB;
      if (!it.last_byte) begin
        pos = len;
        return;
      end
      for (int s = 0; s < NSLOT; s++) begin
        if (!sl_en[s] || sl_src[s] != it.src_addr || sl_dst[s] != it.dst_addr) continue;
        w = eff_w(sl_wid[s]);
        fin = sl_off[s] + w;
        lst = (fin - 1) / 8;
        v = accum[s];
        ovr = 0;
        if (lst >= len) begin
          miss = lst - len + 1;
          ovr = 1;
          v = (miss >= 4) ? 32'd0 : v << (8 * miss);
        end
        v = v >> (sl_off[s] % 8);
        if (sl_sgn[s] && w < 32 && v[w-1]) v |= ~((32'd1 << w) - 1);
        if (active[s]) begin
          if (v != held[s]) begin
            emit_change(s, it.timestamp); n++;
            held[s] = v; since[s] = it.timestamp; overrun[s] = ovr;
          end
        end else begin
          active[s] = 1; held[s] = v; since[s] = it.timestamp; overrun[s] = ovr;
        end
      end
      pos = 0;
      foreach (accum[s]) accum[s] = '0;
    end else if (it.action == pfce_pkg::ACT_FINISH) begin
      for (int s = 0; s < NSLOT; s++)
        if (active[s]) begin
          emit_change(s, it.timestamp); n++;
          active[s] = 0;
        end
      pos = 0;
      foreach (accum[s]) accum[s] = '0;
    end
    if (n > 0) expected_q[$].last_event = 1'b1;
  endtask

  // valid stays up after acceptance so the next word can follow at once
  task automatic send_word(pfce_pkg::item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict(it);
  endtask

  // receiver stall bursts
  initial begin
    int k;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, 3);
        repeat (k) begin
          result_stall <= 1'b1;
          @(posedge clk);
        end
      end
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    pfce_pkg::result_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, result);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (result.signal_slot != e.signal_slot)
          $display("%0t slot exp %0d got %0d", $time, e.signal_slot, result.signal_slot);
        if (result.start_time != e.start_time)
          $display("%0t start exp %0d got %0d", $time, e.start_time, result.start_time);
        if (result.end_time != e.end_time)
          $display("%0t end exp %0d got %0d", $time, e.end_time, result.end_time);
        if (result.value_out != e.value_out)
          $display("%0t value exp %h got %h", $time, e.value_out, result.value_out);
        if (result.out_of_range != e.out_of_range)
          $display("%0t oor exp %0d got %0d", $time, e.out_of_range, result.out_of_range);
        if (result.last_event != e.last_event)
          $display("%0t last exp %0d got %0d", $time, e.last_event, result.last_event);
        if (result != e) errors++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("[packet_field_change_extractor] ERROR");
      $finish;
    end
  end

  function automatic pfce_pkg::item_t mk_load(int s, int sa, int da, int off, int w,
                                              bit sg, bit en);
    pfce_pkg::item_t it;
    it = '0;
    it.action = pfce_pkg::ACT_LOAD; it.slot = 4'(s);
    it.src_addr = 7'(sa); it.dst_addr = 7'(da);
    it.field_pos = 11'(off); it.field_size = 6'(w);
    it.is_signed = sg; it.slot_enable = en;
    it.timestamp = 63'({$urandom, $urandom}); it.data_byte = 8'($urandom);
    return it;
  endfunction

  function automatic pfce_pkg::item_t mk_byte(int sa, int da, logic [7:0] b, bit lst,
                                              logic [62:0] t);
    pfce_pkg::item_t it;
    it = '0;
    it.action = pfce_pkg::ACT_BYTE; it.src_addr = 7'(sa); it.dst_addr = 7'(da);
    it.data_byte = b; it.last_byte = lst; it.timestamp = t;
    it.slot = 4'($urandom); it.field_pos = 11'($urandom); it.field_size = 6'($urandom);
    return it;
  endfunction

  function automatic pfce_pkg::item_t mk_finish(logic [62:0] t);
    pfce_pkg::item_t it;
    it = '0;
    it.action = pfce_pkg::ACT_FINISH; it.timestamp = t;
    return it;
  endfunction

  task automatic send_packet(int sa, int da, int nbytes, logic [62:0] t);
    for (int i = 0; i < nbytes; i++)
      send_word(mk_byte(sa, da, 8'($urandom), i == nbytes - 1, t));
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic test_directed();
    pfce_pkg::item_t it;
    send_word(mk_load(0, 127, 0, 0, 32, 1, 1));
    send_word(mk_load(1, 127, 0, 3, 5, 1, 1));
    send_word(mk_load(2, 127, 0, 2040, 1, 0, 1));     // beyond packet end
    send_word(mk_load(3, 127, 0, 12, 0, 0, 1));       // zero width
    send_word(mk_load(4, 127, 0, 7, 63, 0, 1));       // over-wide
    send_word(mk_load(15, 0, 127, 0, 8, 0, 0));       // disabled
    send_packet(127, 0, 4, 63'd1);
    send_word(mk_byte(127, 0, 8'hff, 1, 63'h7fffffffffffffff));
    it = mk_byte(127, 0, 8'h00, 0, 63'd5);
    it.action = pfce_pkg::ACT_RSVD;                   // unknown action, ignored
    send_word(it);
    send_packet(127, 0, 5, 63'd9);
    send_word(mk_load(1, 127, 0, 3, 5, 0, 1));        // reload drops held value
    send_word(mk_finish(63'h7fffffffffffffff));
    send_word(mk_finish(63'd0));                      // nothing to flush
  endtask

  task automatic test_short_packet();
    send_word(mk_load(5, 10, 11, 30, 16, 1, 1));      // spans bytes 3 to 5
    send_packet(10, 11, 6, 63'd100);
    send_packet(10, 11, 6, 63'd200);
    send_packet(10, 11, 4, 63'd300);                  // short: overrun
    send_packet(10, 11, 2, 63'd350);                  // every field byte missing
    send_word(mk_finish(63'd400));
    wait_drained();
  endtask

  task automatic test_random(int nwords);
    int cnt;
    logic [62:0] t;
    cnt = 0;
    t = 63'd1000;
    for (int s = 0; s < NSLOT; s++)
      send_word(mk_load(s, $urandom_range(0, 1) ? 7'd3 : 7'd120, 7'd5,
                        $urandom_range(0, 60), $urandom_range(0, 63),
                        1'($urandom), $urandom_range(0, 5) != 0));
    while (cnt < nwords) begin
      int r, n;
      r = $urandom_range(0, 19);
      t = t + $urandom_range(1, 1000);
      if ($urandom_range(0, 30) == 0) t = 63'({$urandom, $urandom});
      if (r < 14) begin
        n = $urandom_range(1, 9);
        send_packet($urandom_range(0, 3) == 0 ? $urandom_range(0, 127) :
                    ($urandom_range(0, 1) ? 3 : 120), 5, n, t);
        cnt += n;
      end else if (r < 17) begin
        send_word(mk_load($urandom_range(0, 15), $urandom_range(0, 1) ? 7'd3 : 7'd120, 7'd5,
                          $urandom_range(0, 2047), $urandom_range(0, 63),
                          1'($urandom), 1'($urandom)));
        cnt++;
      end else if (r < 19) begin
        send_word(mk_byte($urandom, $urandom, 8'($urandom), 0, t));
        send_word(mk_finish(t));
        cnt += 2;
      end else begin
        wait_drained();                               // sender holds off
        cnt++;
      end
    end
    send_word(mk_finish(t + 1));
  endtask

  initial begin
    foreach (sl_en[s]) begin
      sl_src[s] = 0; sl_dst[s] = 0; sl_off[s] = 0; sl_wid[s] = 0;
      sl_sgn[s] = 0; sl_en[s] = 0; accum[s] = 0; held[s] = 0;
      since[s] = 0; active[s] = 0; overrun[s] = 0;
    end
    pos = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_short_packet();
    test_random(100);
    idle_on = 1'b0;
    test_random(40);
    item_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("[packet_field_change_extractor] OK");
    else
      $display("[packet_field_change_extractor] ERROR");
    $finish;
  end
endmodule
